[hw/rtl/ssrl_pkg.sv]
// ----------------------------------------------------------------------------
// ssrl_pkg: shared types and codes of the sorted symbol range lookup unit
// Transaction payloads, stored entry format and the sequencer states.
// ----------------------------------------------------------------------------
`default_nettype none

package ssrl_pkg;

   localparam logic FUNC_LOAD   = 1'b0;
   localparam logic FUNC_LOOKUP = 1'b1;

   typedef struct packed {
      logic        func;
      logic [1:0]  table_id;
      logic [63:0] entry_offset;
      logic [63:0] entry_size;
      logic [31:0] entry_tag;
      logic        last_entry;
      logic [63:0] lookup_address;
   } req_type;

   typedef struct packed {
      logic        found;
      logic [63:0] match_offset;
      logic [63:0] match_size;
      logic [31:0] match_tag;
      logic        table_present;
      logic        overflow;
   } rsp_type;

   typedef struct packed {
      logic [63:0] offset;
      logic [63:0] size;
      logic [31:0] tag;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_INS_RD,
      ST_INS_CMP,
      ST_LOAD_END,
      ST_INST_RD,
      ST_INST_WR,
      ST_LK_RD,
      ST_LK_CMP,
      ST_EQ_RD,
      ST_EQ_CHK,
      ST_PRED_RD,
      ST_PRED_CHK,
      ST_DONE
   } state_type;

endpackage

`default_nettype wire

[hw/rtl/ssrl_ram.sv]
// ----------------------------------------------------------------------------
// ssrl_ram: generic simple dual-port RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
`default_nettype none

module ssrl_ram #(
   parameter int WIDTH = 160,
   parameter int DEPTH = 1024
) (
   input  wire                      clock,
   input  wire                      wr_en,
   input  wire [$clog2(DEPTH)-1:0] wr_addr,
   input  wire [WIDTH-1:0]          wr_data,
   input  wire [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

`default_nettype wire

[hw/rtl/sorted_symbol_range_lookup_unit.sv]
// ----------------------------------------------------------------------------
// sorted_symbol_range_lookup_unit: symbol tables with interval lookup
// Staged sorted loads, deduplicating install and binary-search lookups.
// ----------------------------------------------------------------------------
// The unit holds NUM_TABLES symbol tables in one table RAM and builds a new
// table in a staging RAM. A load transaction inserts its entry into the
// staging list by walking down from the top, with one RAM read and a compare
// for each staged entry with a larger offset, which moves up one slot. A load
// with last_entry set then copies the staged list into the named table,
// dropping adjacent duplicates. A lookup is a lower-bound binary search over
// the table RAM, each halving step a read and then a compare. Each RAM has a
// single read port. One transaction is worked on at a time; a new one is
// taken as soon as the sequencer is idle, even while the previous result
// still waits on rsp_stall. Every transaction yields exactly one result
// transaction. The RAMs need no clearing after reset: only entries below the
// fill counts are ever read.
// ----------------------------------------------------------------------------
`default_nettype none

module sorted_symbol_range_lookup_unit #(
   parameter int NUM_TABLES  = 4,
   parameter int TABLE_DEPTH = 1024
) (
   input  wire               clock,
   input  wire               reset,
   input  wire               req_valid,
   output logic              req_stall,
   input  ssrl_pkg::req_type req_data,
   output logic              rsp_valid,
   input  wire               rsp_stall,
   output ssrl_pkg::rsp_type rsp_data
);

   import ssrl_pkg::*;

   localparam int CW  = $clog2(TABLE_DEPTH + 1);   // counts up to the depth
   localparam int IW  = $clog2(TABLE_DEPTH);       // index into one table
   localparam int TIW = (NUM_TABLES > 1) ? $clog2(NUM_TABLES) : 1;
   localparam int TD  = NUM_TABLES * TABLE_DEPTH;
   localparam int TAW = $clog2(TD);

   // Sequencer and transaction registers
   state_type        st_ff, st_in;
   req_type          req_ff, req_in;
   logic             tvalid_ff, tvalid_in;
   logic [TIW-1:0]   tsel_ff, tsel_in;
   logic [TAW-1:0]   base_ff, base_in;
   logic [CW-1:0]    pos_ff, pos_in;     // insert slot, copy index or search low bound
   logic [CW-1:0]    hi_ff, hi_in;
   logic [CW-1:0]    mid_ff, mid_in;
   logic [CW-1:0]    n_ff, n_in;         // installed count or searched table size
   entry_type        prev_ff, prev_in;
   logic [CW-1:0]    scount_ff, scount_in;
   logic [CW-1:0]    counts_ff [NUM_TABLES];
   logic [CW-1:0]    counts_in [NUM_TABLES];
   logic             present_ff [NUM_TABLES];
   logic             present_in [NUM_TABLES];
   logic             ovf_ff, ovf_in;
   logic             hit_ff, hit_in;
   entry_type        hitent_ff, hitent_in;

   // Result register
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_type          rsp_ff, rsp_in;

   // RAM ports
   logic             st_we;
   logic [IW-1:0]    st_waddr, st_raddr;
   entry_type        st_wdata, st_rdata;
   logic             tb_we;
   logic [TAW-1:0]   tb_waddr, tb_raddr;
   entry_type        tb_wdata, tb_rdata;

   // Helpers
   entry_type        new_ent;
   logic             req_tvalid;
   logic [TIW-1:0]   req_tsel;
   logic [CW-1:0]    mid_calc;
   logic             dup;
   logic             out_free;
   logic [64:0]      pred_end;

   assign new_ent    = '{offset: req_ff.entry_offset, size: req_ff.entry_size,
                         tag: req_ff.entry_tag};
   assign req_tvalid = 32'(req_data.table_id) < NUM_TABLES;
   assign req_tsel   = TIW'(req_data.table_id);
   assign mid_calc   = pos_ff + ((hi_ff - pos_ff) >> 1);
   assign dup        = (n_ff != '0) && (prev_ff.offset == st_rdata.offset) &&
                       (prev_ff.size == st_rdata.size);
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign pred_end   = {1'b0, tb_rdata.offset} + {1'b0, tb_rdata.size};

   ssrl_ram #(.WIDTH(ENTRY_W), .DEPTH(TABLE_DEPTH)) u_staging (
      .clock   (clock),
      .wr_en   (st_we),
      .wr_addr (st_waddr),
      .wr_data (st_wdata),
      .rd_addr (st_raddr),
      .rd_data (st_rdata)
   );

   ssrl_ram #(.WIDTH(ENTRY_W), .DEPTH(TD)) u_tables (
      .clock   (clock),
      .wr_en   (tb_we),
      .wr_addr (tb_waddr),
      .wr_data (tb_wdata),
      .rd_addr (tb_raddr),
      .rd_data (tb_rdata)
   );

   // Next state
   always_comb begin
      st_in = st_ff;
      case (st_ff)
         ST_IDLE: begin
            if (req_valid) begin
               if (req_data.func == FUNC_LOAD) begin
                  // drop the entry when staging is full
                  st_in = (32'(scount_ff) >= TABLE_DEPTH) ? ST_LOAD_END : ST_INS_RD;
               end else begin
                  st_in = req_tvalid ? ST_LK_RD : ST_DONE;
               end
            end
         end
         ST_INS_RD:   st_in = (pos_ff == '0) ? ST_LOAD_END : ST_INS_CMP;
         ST_INS_CMP:  st_in = (st_rdata.offset > req_ff.entry_offset) ? ST_INS_RD
                                                                      : ST_LOAD_END;
         ST_LOAD_END: st_in = (req_ff.last_entry && tvalid_ff) ? ST_INST_RD : ST_DONE;
         ST_INST_RD:  st_in = (pos_ff < scount_ff) ? ST_INST_WR : ST_DONE;
         ST_INST_WR:  st_in = ST_INST_RD;
         ST_LK_RD:    st_in = (pos_ff < hi_ff) ? ST_LK_CMP : ST_EQ_RD;
         ST_LK_CMP:   st_in = ST_LK_RD;
         ST_EQ_RD: begin
            if (pos_ff < n_ff) begin
               st_in = ST_EQ_CHK;
            end else begin
               st_in = (pos_ff != '0) ? ST_PRED_RD : ST_DONE;
            end
         end
         ST_EQ_CHK: begin
            if (tb_rdata.offset == req_ff.lookup_address) begin
               st_in = ST_DONE;
            end else begin
               st_in = (pos_ff != '0) ? ST_PRED_RD : ST_DONE;
            end
         end
         ST_PRED_RD:  st_in = ST_PRED_CHK;
         ST_PRED_CHK: st_in = ST_DONE;
         ST_DONE:     st_in = out_free ? ST_IDLE : ST_DONE;
         default:     st_in = ST_IDLE;
      endcase
   end

   // RAM controls and handshake
   always_comb begin
      req_stall = (st_ff != ST_IDLE);
      st_we     = 1'b0;
      st_waddr  = pos_ff[IW-1:0];
      st_wdata  = new_ent;
      st_raddr  = pos_ff[IW-1:0];
      tb_we     = 1'b0;
      tb_waddr  = base_ff + TAW'(n_ff);
      tb_wdata  = st_rdata;
      tb_raddr  = base_ff + TAW'(pos_ff);
      case (st_ff)
         ST_INS_RD: begin
            if (pos_ff == '0) begin
               st_we = 1'b1;
            end else begin
               st_raddr = IW'(pos_ff - 1'b1);
            end
         end
         ST_INS_CMP: begin
            st_we = 1'b1;
            if (st_rdata.offset > req_ff.entry_offset) begin
               st_wdata = st_rdata;
            end
         end
         ST_INST_WR: tb_we = !dup;
         ST_LK_RD:   tb_raddr = base_ff + TAW'(mid_calc);
         ST_PRED_RD: tb_raddr = base_ff + TAW'(pos_ff - 1'b1);
         default: ;
      endcase
   end

   // Datapath next values
   always_comb begin
      req_in     = req_ff;
      tvalid_in  = tvalid_ff;
      tsel_in    = tsel_ff;
      base_in    = base_ff;
      pos_in     = pos_ff;
      hi_in      = hi_ff;
      mid_in     = mid_ff;
      n_in       = n_ff;
      prev_in    = prev_ff;
      scount_in  = scount_ff;
      counts_in  = counts_ff;
      present_in = present_ff;
      ovf_in     = ovf_ff;
      hit_in     = hit_ff;
      hitent_in  = hitent_ff;
      case (st_ff)
         ST_IDLE: begin
            if (req_valid) begin
               req_in    = req_data;
               tvalid_in = req_tvalid;
               tsel_in   = req_tsel;
               base_in   = TAW'(req_tsel) * TAW'(TABLE_DEPTH);
               ovf_in    = (req_data.func == FUNC_LOAD) && (32'(scount_ff) >= TABLE_DEPTH);
               hit_in    = 1'b0;
               if (req_data.func == FUNC_LOAD) begin
                  pos_in = scount_ff;
               end else if (req_tvalid) begin
                  // an absent table becomes present and empty
                  pos_in = '0;
                  if (!present_ff[req_tsel]) begin
                     present_in[req_tsel] = 1'b1;
                     counts_in[req_tsel]  = '0;
                     hi_in = '0;
                     n_in  = '0;
                  end else begin
                     hi_in = counts_ff[req_tsel];
                     n_in  = counts_ff[req_tsel];
                  end
               end
            end
         end
         ST_INS_RD: begin
            if (pos_ff == '0) begin
               scount_in = scount_ff + 1'b1;
            end
         end
         ST_INS_CMP: begin
            if (st_rdata.offset > req_ff.entry_offset) begin
               pos_in = pos_ff - 1'b1;
            end else begin
               scount_in = scount_ff + 1'b1;
            end
         end
         ST_LOAD_END: begin
            if (req_ff.last_entry) begin
               pos_in = '0;
               n_in   = '0;
               if (!tvalid_ff) begin
                  scount_in = '0;
               end
            end
         end
         ST_INST_RD: begin
            if (!(pos_ff < scount_ff)) begin
               counts_in[tsel_ff]  = n_ff;
               present_in[tsel_ff] = 1'b1;
               scount_in = '0;
            end
         end
         ST_INST_WR: begin
            pos_in = pos_ff + 1'b1;
            if (!dup) begin
               prev_in = st_rdata;
               n_in    = n_ff + 1'b1;
            end
         end
         ST_LK_RD: mid_in = mid_calc;
         ST_LK_CMP: begin
            if (tb_rdata.offset < req_ff.lookup_address) begin
               pos_in = mid_ff + 1'b1;
            end else begin
               hi_in = mid_ff;
            end
         end
         ST_EQ_CHK: begin
            if (tb_rdata.offset == req_ff.lookup_address) begin
               hit_in    = 1'b1;
               hitent_in = tb_rdata;
            end
         end
         ST_PRED_CHK: begin
            // open-ended entry, or wrapped end above the address
            if ((tb_rdata.offset <= req_ff.lookup_address) &&
                ((pred_end[63:0] > req_ff.lookup_address) || (tb_rdata.size == '0))) begin
               hit_in    = 1'b1;
               hitent_in = tb_rdata;
            end
         end
         default: ;
      endcase
   end

   // Result register: load on completion, drop once taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_in       = rsp_ff;
      if ((st_ff == ST_DONE) && out_free) begin
         rsp_valid_in         = 1'b1;
         rsp_in.found         = hit_ff;
         rsp_in.match_offset  = hit_ff ? hitent_ff.offset : '0;
         rsp_in.match_size    = hit_ff ? hitent_ff.size : '0;
         rsp_in.match_tag     = hit_ff ? hitent_ff.tag : '0;
         rsp_in.table_present = tvalid_ff && present_ff[tsel_ff];
         rsp_in.overflow      = ovf_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff        <= ST_IDLE;
         scount_ff    <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < NUM_TABLES; i++) begin
            counts_ff[i]  <= '0;
            present_ff[i] <= 1'b0;
         end
      end else begin
         st_ff        <= st_in;
         scount_ff    <= scount_in;
         rsp_valid_ff <= rsp_valid_in;
         counts_ff    <= counts_in;
         present_ff   <= present_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff    <= req_in;
      tvalid_ff <= tvalid_in;
      tsel_ff   <= tsel_in;
      base_ff   <= base_in;
      pos_ff    <= pos_in;
      hi_ff     <= hi_in;
      mid_ff    <= mid_in;
      n_ff      <= n_in;
      prev_ff   <= prev_in;
      ovf_ff    <= ovf_in;
      hit_ff    <= hit_in;
      hitent_ff <= hitent_in;
      rsp_ff    <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

`default_nettype wire

[dv/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top: regression bench for the sorted symbol range lookup unit
// Directed and random load runs and lookups go in through a queue-fed driver.
// A behavioral copy of the table store predicts every result transaction, and
// the monitor compares each accepted result field by field.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import ssrl_pkg::*;

   localparam int NUM_TABLES  = 4;
   localparam int TABLE_DEPTH = 1024;
   localparam int STALL_LIMIT = 20000;   // cycles with no transaction on either side
   localparam int HINT_MAX    = 64;

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_stall;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_stall;
   rsp_type rsp_data;

   sorted_symbol_range_lookup_unit #(
      .NUM_TABLES (NUM_TABLES),
      .TABLE_DEPTH(TABLE_DEPTH)
   ) dut (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data (rsp_data)
   );

   // Shadow of the unit: staged run and installed tables.
   entry_type staged_run[TABLE_DEPTH];
   int        staged_cnt;
   entry_type sym_store[NUM_TABLES][TABLE_DEPTH];
   int        sym_cnt[NUM_TABLES];
   bit        sym_live[NUM_TABLES];

   req_type     pending_reqs[$];     // items waiting to be driven
   rsp_type     expected_rsps[$];    // predicted results, oldest first
   logic [63:0] addr_hints[$];       // offsets and ends of recent loads
   int          err_count;
   int          send_idle_pct;
   int          stall_pct;
   bit          hold_sends;

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Compute the result of one accepted transaction and advance the shadow state.
   function automatic rsp_type predict_symbol_rsp(req_type r);
      rsp_type     o;
      entry_type   e;
      int          pos;
      int          lo;
      int          n;
      int          t;
      logic [63:0] po;
      logic [63:0] ps;
      o = '0;
      t = int'(r.table_id);
      if (r.func == FUNC_LOAD) begin
         if (staged_cnt >= TABLE_DEPTH) begin
            o.overflow = 1'b1;
         end else begin
            // stable insert: after every staged entry with an equal offset
            pos = staged_cnt;
            while (pos > 0 && staged_run[pos-1].offset > r.entry_offset) pos--;
            for (int k = staged_cnt; k > pos; k--) staged_run[k] = staged_run[k-1];
            e.offset = r.entry_offset;
            e.size   = r.entry_size;
            e.tag    = r.entry_tag;
            staged_run[pos] = e;
            staged_cnt++;
         end
         if (r.last_entry) begin
            n = 0;
            for (int i = 0; i < staged_cnt; i++) begin
               if (n > 0 && sym_store[t][n-1].offset == staged_run[i].offset &&
                   sym_store[t][n-1].size == staged_run[i].size)
                  continue;
               sym_store[t][n] = staged_run[i];
               n++;
            end
            sym_cnt[t]  = n;
            sym_live[t] = 1'b1;
            staged_cnt  = 0;
         end
      end else begin
         // a lookup on an absent table creates it empty
         if (!sym_live[t]) begin
            sym_live[t] = 1'b1;
            sym_cnt[t]  = 0;
         end
         lo = 0;
         while (lo < sym_cnt[t] && sym_store[t][lo].offset < r.lookup_address) lo++;
         pos = -1;
         if (lo < sym_cnt[t] && sym_store[t][lo].offset == r.lookup_address) begin
            pos = lo;
         end else if (lo > 0) begin
            po = sym_store[t][lo-1].offset;
            ps = sym_store[t][lo-1].size;
            if (po <= r.lookup_address && (po + ps > r.lookup_address || ps == 0))
               pos = lo - 1;
         end
         if (pos >= 0) begin
            o.found        = 1'b1;
            o.match_offset = sym_store[t][pos].offset;
            o.match_size   = sym_store[t][pos].size;
            o.match_tag    = sym_store[t][pos].tag;
         end
      end
      o.table_present = sym_live[t];
      return o;
   endfunction

   task automatic report_mismatch(string field, logic [63:0] got, logic [63:0] want);
      $display("[%0t] mismatch on %s: got 0x%h, expected 0x%h", $realtime, field, got, want);
      err_count++;
   endtask

   // Driver: present the next pending transaction; hold a stalled one unchanged.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         req_data  <= '0;
      end else begin
         if (req_valid && !req_stall)
            expected_rsps.push_back(predict_symbol_rsp(req_data));
         if (!req_valid || !req_stall) begin
            if (pending_reqs.size() > 0 && !hold_sends &&
                $urandom_range(99) >= send_idle_pct) begin
               req_valid <= 1'b1;
               req_data  <= pending_reqs.pop_front();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Monitor: check each accepted result against the oldest prediction.
   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_rsps.size() == 0) begin
               $display("[%0t] result transaction with nothing expected", $realtime);
               err_count++;
            end else begin
               want = expected_rsps.pop_front();
               if (rsp_data.found !== want.found)
                  report_mismatch("found", 64'(rsp_data.found), 64'(want.found));
               if (rsp_data.match_offset !== want.match_offset)
                  report_mismatch("match_offset", rsp_data.match_offset, want.match_offset);
               if (rsp_data.match_size !== want.match_size)
                  report_mismatch("match_size", rsp_data.match_size, want.match_size);
               if (rsp_data.match_tag !== want.match_tag)
                  report_mismatch("match_tag", 64'(rsp_data.match_tag),
                                  64'(want.match_tag));
               if (rsp_data.table_present !== want.table_present)
                  report_mismatch("table_present", 64'(rsp_data.table_present),
                                  64'(want.table_present));
               if (rsp_data.overflow !== want.overflow)
                  report_mismatch("overflow", 64'(rsp_data.overflow), 64'(want.overflow));
            end
         end
         rsp_stall <= ($urandom_range(99) < stall_pct);
      end
   end

   // Watchdog: end the run when neither channel moves for too long.
   always @(posedge clock) begin
      int quiet;
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet = 0;
      end else begin
         quiet++;
         if (quiet >= STALL_LIMIT) begin
            $display("sorted_symbol_range_lookup_unit regression: fail");
            $finish;
         end
      end
   end

   function automatic logic [63:0] rand64();
      return {$urandom, $urandom};
   endfunction

   // Fill every field with noise; callers overwrite the ones that matter.
   function automatic req_type noise_req();
      req_type r;
      r.func           = 1'($urandom_range(1));
      r.table_id       = 2'($urandom_range(3));
      r.entry_offset   = rand64();
      r.entry_size     = rand64();
      r.entry_tag      = $urandom;
      r.last_entry     = 1'($urandom_range(1));
      r.lookup_address = rand64();
      return r;
   endfunction

   task automatic add_load(int t, logic [63:0] off, logic [63:0] sz, logic [31:0] tag,
                           bit last);
      req_type r;
      r = noise_req();
      r.func         = FUNC_LOAD;
      r.table_id     = 2'(t);
      r.entry_offset = off;
      r.entry_size   = sz;
      r.entry_tag    = tag;
      r.last_entry   = last;
      pending_reqs.push_back(r);
      addr_hints.push_back(off);
      addr_hints.push_back(off + sz);
      while (addr_hints.size() > HINT_MAX) void'(addr_hints.pop_front());
   endtask

   task automatic add_lookup(int t, logic [63:0] addr);
      req_type r;
      r = noise_req();
      r.func           = FUNC_LOOKUP;
      r.table_id       = 2'(t);
      r.lookup_address = addr;
      pending_reqs.push_back(r);
   endtask

   function automatic logic [63:0] pick_offset();
      case ($urandom_range(4))
         0: return 64'($urandom_range(15)) * 64'd64;
         1: return rand64();
         2: return 64'hFFFF_FFFF_FFFF_FF00 + 64'($urandom_range(255));
         default: begin
            if (addr_hints.size() == 0) return 64'($urandom_range(1023));
            return addr_hints[$urandom_range(addr_hints.size() - 1)];
         end
      endcase
   endfunction

   function automatic logic [63:0] pick_size();
      case ($urandom_range(4))
         0: return 64'd0;
         1: return 64'($urandom_range(1, 200));
         2: return rand64();
         default: return 64'd64;
      endcase
   endfunction

   // Aim near a known boundary most of the time: on it, one below, one above, or up to 100 above.
   function automatic logic [63:0] pick_addr();
      logic [63:0] base;
      if (addr_hints.size() == 0 || $urandom_range(9) == 0) return rand64();
      base = addr_hints[$urandom_range(addr_hints.size() - 1)];
      case ($urandom_range(3))
         0: return base - 64'd1;
         1: return base + 64'd1;
         2: return base + 64'($urandom_range(100));
         default: return base;
      endcase
   endfunction

   // One load run with random content, sometimes broken up by lookups,
   // followed by a burst of lookups.
   task automatic add_random_run();
      int t;
      int n;
      t = $urandom_range(3);
      n = $urandom_range(1, 12);
      for (int i = 0; i < n; i++) begin
         add_load((i == n - 1) ? t : $urandom_range(3), pick_offset(), pick_size(),
                  $urandom, i == n - 1);
         if (i < n - 1 && $urandom_range(9) == 0)
            add_lookup($urandom_range(3), pick_addr());
      end
      n = $urandom_range(1, 8);
      for (int i = 0; i < n; i++) add_lookup($urandom_range(3), pick_addr());
   endtask

   task automatic wait_all_sent();
      while (pending_reqs.size() != 0 || req_valid) @(posedge clock);
   endtask

   initial begin
      int idle_set[4];
      int stall_set[4];
      idle_set  = '{0, 77, 0, 31};
      stall_set = '{0, 0, 77, 31};
      reset         = 1'b1;
      req_valid     = 1'b0;
      req_data      = '0;
      rsp_stall     = 1'b0;
      err_count     = 0;
      send_idle_pct = 0;
      stall_pct     = 0;
      hold_sends    = 1'b0;
      staged_cnt    = 0;
      for (int i = 0; i < NUM_TABLES; i++) begin
         sym_cnt[i]  = 0;
         sym_live[i] = 1'b0;
      end
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Directed: absent table, then a run whose earlier items name another table.
      add_lookup(3, 64'h100);
      add_load(2, 64'h100, 64'h10, 32'hA, 1'b0);
      add_load(2, 64'h100, 64'h10, 32'hB, 1'b0);      // adjacent duplicate, dropped
      add_load(2, 64'h100, 64'h20, 32'hC, 1'b0);      // same offset, other size
      add_load(2, 64'h80, 64'h0, 32'hD, 1'b0);        // open-ended entry
      add_load(2, 64'hFFFF_FFFF_FFFF_FFF0, 64'h20, 32'hE, 1'b0);   // end wraps
      add_load(1, 64'h200, 64'h10, 32'hF, 1'b0);
      add_load(0, 64'h100, 64'h10, 32'h1234_5678, 1'b1);
      add_lookup(0, 64'h100);                  // exact: first of the group
      add_lookup(0, 64'h118);                  // past the predecessor's end
      add_lookup(0, 64'h90);                   // covered by the open-ended entry
      add_lookup(0, 64'h0);                    // below every entry
      add_lookup(0, 64'hFFFF_FFFF_FFFF_FFFF);  // wrapped end does not cover
      add_lookup(0, 64'hFFFF_FFFF_FFFF_FFF0);
      add_lookup(0, 64'h20F);
      add_lookup(0, 64'h210);
      add_lookup(2, 64'h100);                  // never installed: becomes empty
      add_load(1, '1, '1, '1, 1'b1);
      add_lookup(1, '1);
      add_lookup(1, 64'hFFFF_FFFF_FFFF_FFFE);
      add_load(3, 64'h0, 64'h0, 32'h0, 1'b1);
      add_lookup(3, 64'h0);
      add_lookup(3, 64'h5);
      wait_all_sent();

      for (int ph = 0; ph < 8; ph++) begin
         send_idle_pct = idle_set[ph % 4];
         stall_pct     = stall_set[ph % 4];
         if (ph == 2) begin
            // Overfill the staging list; the dropped loads still end the run.
            for (int i = 0; i < TABLE_DEPTH + 6; i++)
               add_load($urandom_range(3), 64'(i) * 64'd32, 64'd32, $urandom,
                        i == TABLE_DEPTH + 5);
            for (int i = 0; i < 6; i++) add_lookup($urandom_range(3), pick_addr());
         end
         while (pending_reqs.size() < 120) add_random_run();
         if (ph == 5) begin
            // Pause the sender mid-phase until every result has drained.
            while (pending_reqs.size() > 60) @(posedge clock);
            hold_sends = 1'b1;
            while (expected_rsps.size() != 0 || req_valid) @(posedge clock);
            hold_sends = 1'b0;
         end
         wait_all_sent();
      end

      while (expected_rsps.size() != 0) @(posedge clock);
      repeat (60) @(posedge clock);
      if (err_count == 0)
         $display("sorted_symbol_range_lookup_unit regression: pass");
      else
         $display("sorted_symbol_range_lookup_unit regression: fail");
      $finish;
   end

endmodule

`default_nettype wire

[sim.f]
hw/rtl/ssrl_pkg.sv
hw/rtl/ssrl_ram.sv
hw/rtl/sorted_symbol_range_lookup_unit.sv
dv/tb_top.sv
